@@ rtl/qlt_pkg.sv @@
// ----------------------------------------------------------------------------
// qlt_pkg
// Types and byte constants shared by the quoted line tokenizer.
// ----------------------------------------------------------------------------
package qlt_pkg;

  typedef enum logic [1:0] {
    MODE_GAP   = 2'd0,
    MODE_BARE  = 2'd1,
    MODE_QUOTE = 2'd2,
    MODE_SKIP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_END    = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_NL    = 8'h0A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_QUOTE = 8'h22;
  localparam logic [7:0] BYTE_HASH  = 8'h23;
  localparam logic [7:0] BYTE_BSL   = 8'h5C;
  localparam logic [7:0] BYTE_N     = 8'h6E;
  localparam logic [7:0] BYTE_T     = 8'h74;

  // Most words a single byte can produce (char, end, verdict)
  localparam int unsigned MAX_RES = 3;

  function automatic logic is_delim(input logic [7:0] b);
    return (b == BYTE_SPACE) || (b == BYTE_TAB) || (b == BYTE_QUOTE) ||
           (b == BYTE_HASH) || (b == BYTE_NUL);
  endfunction

endpackage

@@ rtl/quoted_line_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// quoted_line_tokenizer_top
// Splits a byte stream into lines and shell-style quoted tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one text byte per word in s_tdata; s_tlast set means
//   end of input (the byte is ignored and an unfinished line is closed).
//   Output channel m_*: m_tuser is the word kind (token char, token end,
//   line accepted, line rejected), m_tdata the token char (zero otherwise),
//   m_tlast marks the final word caused by one input byte.
//   Each accepted byte is decoded in the cycle of acceptance into up to three
//   words held in a three-entry result buffer; the first word is visible on
//   m_* in the cycle after acceptance.
//   Throughput: one byte per cycle while each byte yields at most one word
//   and m_tready is high; a byte yielding more words holds the input until
//   its last word leaves, as the single output port drains the result buffer
//   one word a cycle while m_tready is high. s_tready is high when the buffer
//   is empty or its last word leaves in the same cycle. A stalled receiver
//   (m_tready low) holds the current word and backs up the input channel.
//   Reset clears the scan state (between tokens, no open line) and empties
//   the result buffer.
module quoted_line_tokenizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // end_of_input
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] char_out
  output logic [1:0] m_tuser,   // [1:0] kind
  output logic       m_tlast    // last
);
  import qlt_pkg::*;

  // scan state
  mode_t mode, mode_next;
  logic  esc, esc_next;
  logic  line_open, line_open_next;
  logic  quote_text, quote_text_next;
  logic  line_bad, line_bad_next;

  // result buffer
  kind_t      buf_kind [MAX_RES];
  logic [7:0] buf_char [MAX_RES];
  logic       buf_last [MAX_RES];
  logic [1:0] head;
  logic [1:0] count;

  // decoded results of the incoming byte
  kind_t      res_kind [MAX_RES];
  logic [7:0] res_char [MAX_RES];
  logic [1:0] res_cnt;

  logic accept, pop;
  logic line_end, tok, delim;
  logic [7:0] b;

  assign b        = s_tdata;
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign delim    = is_delim(b);
  assign line_end = s_tlast ? line_open : (b == BYTE_NL);
  // byte goes through the escape / literal path
  assign tok = !s_tlast && (b != BYTE_NL) &&
               ((((mode == MODE_GAP) || (mode == MODE_BARE)) && !delim) ||
                ((mode == MODE_QUOTE) && (b != BYTE_QUOTE) && (b != BYTE_NUL)));

  assign s_tready = (count == 2'd0) || ((count == 2'd1) && m_tready);
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = buf_char[head];
  assign m_tuser  = buf_kind[head];
  assign m_tlast  = buf_last[head];

  // next scan state
  always_comb begin
    mode_next       = mode;
    esc_next        = esc;
    line_open_next  = line_open;
    quote_text_next = quote_text;
    line_bad_next   = line_bad;
    if (line_end) begin
      mode_next       = MODE_GAP;
      esc_next        = 1'b0;
      line_open_next  = 1'b0;
      quote_text_next = 1'b0;
      line_bad_next   = 1'b0;
    end else if (!s_tlast) begin
      line_open_next = 1'b1;
      if (tok) begin
        esc_next = esc ? 1'b0 : (b == BYTE_BSL);
        if (mode == MODE_GAP) mode_next = MODE_BARE;
        if (mode == MODE_QUOTE) quote_text_next = 1'b1;
      end else begin
        case (mode)
          MODE_GAP, MODE_BARE: begin
            esc_next = 1'b0;
            if (b == BYTE_QUOTE) begin
              mode_next       = MODE_QUOTE;
              quote_text_next = 1'b0;
            end else if ((b == BYTE_HASH) || (b == BYTE_NUL)) begin
              mode_next = MODE_SKIP;
            end else begin
              mode_next = MODE_GAP;
            end
          end
          MODE_QUOTE: begin
            esc_next        = 1'b0;
            quote_text_next = 1'b0;
            if (b == BYTE_QUOTE) begin
              mode_next = MODE_GAP;
            end else begin
              mode_next     = MODE_SKIP;
              line_bad_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // results of the incoming byte
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res_kind[i] = KIND_CHAR;
      res_char[i] = '0;
    end
    res_cnt = '0;
    if (line_end) begin
      if (mode == MODE_BARE) begin
        if (esc) begin
          res_char[res_cnt] = BYTE_BSL;
          res_cnt           = res_cnt + 2'd1;
        end
        res_kind[res_cnt] = KIND_END;
        res_cnt           = res_cnt + 2'd1;
      end
      res_kind[res_cnt] = (line_bad || (mode == MODE_QUOTE)) ? KIND_REJECT : KIND_ACCEPT;
      res_cnt           = res_cnt + 2'd1;
    end else if (tok) begin
      if (esc) begin
        if (b == BYTE_BSL) begin
          res_char[0] = BYTE_BSL;
          res_cnt     = 2'd1;
        end else if (b == BYTE_N) begin
          res_char[0] = BYTE_NL;
          res_cnt     = 2'd1;
        end else if (b == BYTE_T) begin
          res_char[0] = BYTE_TAB;
          res_cnt     = 2'd1;
        end else begin
          res_char[0] = BYTE_BSL;
          res_char[1] = b;
          res_cnt     = 2'd2;
        end
      end else if (b != BYTE_BSL) begin
        res_char[0] = b;
        res_cnt     = 2'd1;
      end
    end else if (!s_tlast && (mode == MODE_BARE)) begin
      // delimiter closes a bare token; a dangling backslash is kept
      if (esc) begin
        res_char[res_cnt] = BYTE_BSL;
        res_cnt           = res_cnt + 2'd1;
      end
      res_kind[res_cnt] = KIND_END;
      res_cnt           = res_cnt + 2'd1;
    end else if (!s_tlast && (mode == MODE_QUOTE) && (b == BYTE_QUOTE)) begin
      if (esc) begin
        res_char[res_cnt] = BYTE_BSL;
        res_cnt           = res_cnt + 2'd1;
      end
      if (esc || quote_text) begin
        res_kind[res_cnt] = KIND_END;
        res_cnt           = res_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_GAP;
      esc        <= 1'b0;
      line_open  <= 1'b0;
      quote_text <= 1'b0;
      line_bad   <= 1'b0;
      head       <= '0;
      count      <= '0;
    end else begin
      if (accept) begin
        mode       <= mode_next;
        esc        <= esc_next;
        line_open  <= line_open_next;
        quote_text <= quote_text_next;
        line_bad   <= line_bad_next;
        head       <= '0;
        count      <= res_cnt;
      end else if (pop) begin
        head  <= head + 2'd1;
        count <= count - 2'd1;
      end
    end
  end

  // payload of the result buffer, loaded on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_RES; i++) begin
        buf_kind[i] <= res_kind[i];
        buf_char[i] <= res_char[i];
        buf_last[i] <= (2'(i) == (res_cnt - 2'd1));
      end
    end
  end

  // the buffer never reads past its third entry
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, head} + {1'b0, count}) <= 3'd3)
    else $error("result buffer read past its end");

  // the final word of a byte is the last one held
  a_last_tail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> count == 2'd1)
    else $error("tlast before the buffer tail");

  // a new byte is taken only when the old words are gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    accept && (count != 2'd0) |-> pop && (count == 2'd1))
    else $error("result buffer overwritten");

  // only token characters carry a byte
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_CHAR) |-> m_tdata == 8'h00)
    else $error("non-char word with data");

  // a newline returns the scanner to its idle state
  a_line_reset: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tlast && (s_tdata == BYTE_NL) |=>
      (mode == MODE_GAP) && !esc && !line_open && !line_bad)
    else $error("scan state not cleared at line end");

endmodule

@@ bench/quoted_line_tokenizer_top_test.sv @@
// ----------------------------------------------------------------------------
// quoted_line_tokenizer_top_test
// Drives text bytes into the tokenizer with bursty input and a stalling
// receiver. Each output word is checked against a typed row's own results
// or a cycle-free scanner model in this bench. Directed bytes run first,
// then randomly built lines of tokens, quotes, escapes, comments and noise.
// ----------------------------------------------------------------------------
module quoted_line_tokenizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qlt_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } res_word_t;

  typedef res_word_t [0:2] res_trio_t;

  // typed rows carry their own results; the rest use the scanner model
  typedef struct packed {
    logic [7:0] text;
    logic       eoi;
    logic       typed;
    logic [1:0] count;
    res_trio_t  fixed_res;
  } stim_row_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] ch;
    logic       last;
  } out_word_t;

  localparam res_word_t NO_W  = {KIND_CHAR, BYTE_NUL};
  localparam res_word_t W_ACC = {KIND_ACCEPT, BYTE_NUL};
  localparam res_word_t W_REJ = {KIND_REJECT, BYTE_NUL};
  localparam res_word_t W_END = {KIND_END, BYTE_NUL};
  localparam res_word_t W_BSL = {KIND_CHAR, BYTE_BSL};
  localparam res_trio_t NO3   = {NO_W, NO_W, NO_W};

  localparam int NUM_DIRECTED = 26;
  localparam int NUM_RANDOM   = 350;

  localparam stim_row_t DIRECTED_TEXT [NUM_DIRECTED] = '{
    // end of input with no line open: nothing
    {BYTE_NUL,   1'b1, 1'b1, 2'd0, NO3},
    // empty line
    {BYTE_NL,    1'b0, 1'b1, 2'd1, {W_ACC, NO_W, NO_W}},
    {8'hFF,      1'b0, 1'b1, 2'd1, {res_word_t'({KIND_CHAR, 8'hFF}), NO_W, NO_W}},
    {BYTE_BSL,   1'b0, 1'b1, 2'd0, NO3},
    // backslash before a delimiter: backslash only, then the token end
    {BYTE_SPACE, 1'b0, 1'b1, 2'd2, {W_BSL, W_END, NO_W}},
    {BYTE_BSL,   1'b0, 1'b0, 2'd0, NO3},
    {BYTE_N,     1'b0, 1'b0, 2'd0, NO3},
    {BYTE_BSL,   1'b0, 1'b0, 2'd0, NO3},
    {8'h01,      1'b0, 1'b0, 2'd0, NO3},
    {BYTE_HASH,  1'b0, 1'b0, 2'd0, NO3},
    {BYTE_NL,    1'b0, 1'b1, 2'd1, {W_ACC, NO_W, NO_W}},
    // backslash before a closing quote
    {BYTE_QUOTE, 1'b0, 1'b0, 2'd0, NO3},
    {BYTE_BSL,   1'b0, 1'b0, 2'd0, NO3},
    {BYTE_QUOTE, 1'b0, 1'b1, 2'd2, {W_BSL, W_END, NO_W}},
    // text right after the closing quote opens a new token
    {8'h41,      1'b0, 1'b0, 2'd0, NO3},
    {BYTE_TAB,   1'b0, 1'b0, 2'd0, NO3},
    // empty quoted token is dropped
    {BYTE_QUOTE, 1'b0, 1'b0, 2'd0, NO3},
    {BYTE_QUOTE, 1'b0, 1'b0, 2'd0, NO3},
    // backslash at line end in a bare token
    {BYTE_BSL,   1'b0, 1'b0, 2'd0, NO3},
    {BYTE_NL,    1'b0, 1'b1, 2'd3, {W_BSL, W_END, W_ACC}},
    // NUL inside quotes
    {BYTE_QUOTE, 1'b0, 1'b0, 2'd0, NO3},
    {BYTE_NUL,   1'b0, 1'b0, 2'd0, NO3},
    {BYTE_NL,    1'b0, 1'b1, 2'd1, {W_REJ, NO_W, NO_W}},
    // quote left open, backslash dropped at end of input
    {BYTE_QUOTE, 1'b0, 1'b0, 2'd0, NO3},
    {BYTE_BSL,   1'b0, 1'b0, 2'd0, NO3},
    {8'hA5,      1'b1, 1'b1, 2'd1, {W_REJ, NO_W, NO_W}}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  quoted_line_tokenizer_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scanner model state
  mode_t     cur_mode   = MODE_GAP;
  logic      esc_held   = 1'b0;
  logic      in_line    = 1'b0;
  logic      quote_text = 1'b0;
  logic      line_fail  = 1'b0;
  res_word_t made [0:2];
  int        made_n;

  out_word_t expected_words [$];
  stim_row_t random_text [$];
  out_word_t want;
  int        fail_count = 0;
  int        burst_left = 0;
  int        stall_left = 0;
  int        stall_mode = 0;

  function automatic void put(kind_t k, logic [7:0] c);
    if (made_n < MAX_RES) begin
      made[made_n] = {k, c};
      made_n++;
    end
  endfunction

  function automatic logic ends_token(logic [7:0] b);
    return b == BYTE_SPACE || b == BYTE_TAB || b == BYTE_QUOTE ||
           b == BYTE_HASH || b == BYTE_NUL;
  endfunction

  function automatic void token_char(logic [7:0] b);
    if (esc_held) begin
      esc_held = 1'b0;
      case (b)
        BYTE_BSL: put(KIND_CHAR, BYTE_BSL);
        BYTE_N:   put(KIND_CHAR, BYTE_NL);
        BYTE_T:   put(KIND_CHAR, BYTE_TAB);
        default: begin
          put(KIND_CHAR, BYTE_BSL);
          put(KIND_CHAR, b);
        end
      endcase
    end else if (b == BYTE_BSL) begin
      esc_held = 1'b1;
    end else begin
      put(KIND_CHAR, b);
    end
  endfunction

  function automatic void after_delim(logic [7:0] b);
    if (b == BYTE_QUOTE) begin
      cur_mode   = MODE_QUOTE;
      quote_text = 1'b0;
    end else if (b == BYTE_HASH || b == BYTE_NUL) begin
      cur_mode = MODE_SKIP;
    end else begin
      cur_mode = MODE_GAP;
    end
  endfunction

  function automatic void close_line();
    logic bad;
    bad = line_fail || cur_mode == MODE_QUOTE;
    if (cur_mode == MODE_BARE) begin
      if (esc_held)
        put(KIND_CHAR, BYTE_BSL);
      put(KIND_END, BYTE_NUL);
    end
    put(bad ? KIND_REJECT : KIND_ACCEPT, BYTE_NUL);
    cur_mode   = MODE_GAP;
    esc_held   = 1'b0;
    quote_text = 1'b0;
    line_fail  = 1'b0;
    in_line    = 1'b0;
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic eoi);
    made_n = 0;
    if (eoi) begin
      if (in_line)
        close_line();
    end else if (b == BYTE_NL) begin
      close_line();
    end else begin
      in_line = 1'b1;
      case (cur_mode)
        MODE_GAP: begin
          if (ends_token(b)) begin
            after_delim(b);
          end else begin
            cur_mode = MODE_BARE;
            token_char(b);
          end
        end
        MODE_BARE: begin
          if (ends_token(b)) begin
            if (esc_held) begin
              put(KIND_CHAR, BYTE_BSL);
              esc_held = 1'b0;
            end
            put(KIND_END, BYTE_NUL);
            after_delim(b);
          end else begin
            token_char(b);
          end
        end
        MODE_QUOTE: begin
          if (b == BYTE_QUOTE) begin
            if (esc_held) begin
              put(KIND_CHAR, BYTE_BSL);
              esc_held   = 1'b0;
              quote_text = 1'b1;
            end
            if (quote_text)
              put(KIND_END, BYTE_NUL);
            quote_text = 1'b0;
            cur_mode   = MODE_GAP;
          end else if (b == BYTE_NUL) begin
            cur_mode   = MODE_SKIP;
            line_fail  = 1'b1;
            esc_held   = 1'b0;
            quote_text = 1'b0;
          end else begin
            quote_text = 1'b1;
            token_char(b);
          end
        end
        default: ;
      endcase
    end
  endfunction

  task automatic add_byte(logic [7:0] b, logic eoi);
    random_text.push_back({b, eoi, 1'b0, 2'd0, NO3});
  endtask

  task automatic add_token_text(int len);
    int r;
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        add_byte(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
      end else if (r < 72) begin
        add_byte(BYTE_BSL, 1'b0);
        case ($urandom_range(0, 3))
          0:       add_byte(BYTE_BSL, 1'b0);
          1:       add_byte(BYTE_N, 1'b0);
          2:       add_byte(BYTE_T, 1'b0);
          default: add_byte(8'($urandom_range(0, 255)), 1'b0);
        endcase
      end else if (r < 82) begin
        add_byte(8'($urandom_range(128, 255)), 1'b0);
      end else begin
        add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // one line of tokens, or now and then a line of raw noise
  task automatic build_line();
    int ntok;
    int r;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 10))
        add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      add_byte(BYTE_NL, 1'b0);
      return;
    end
    ntok = $urandom_range(0, 4);
    for (int i = 0; i < ntok; i++) begin
      if (i > 0 || $urandom_range(0, 2) == 0)
        add_byte($urandom_range(0, 2) == 0 ? BYTE_TAB : BYTE_SPACE, 1'b0);
      r = $urandom_range(0, 9);
      if (r < 5) begin
        add_token_text($urandom_range(1, 6));
      end else if (r < 8) begin
        add_byte(BYTE_QUOTE, 1'b0);
        add_token_text($urandom_range(0, 5));
        if ($urandom_range(0, 9) != 0)
          add_byte(BYTE_QUOTE, 1'b0);
      end else if (r == 8) begin
        add_byte(BYTE_HASH, 1'b0);
        add_token_text($urandom_range(0, 4));
      end else begin
        add_byte(BYTE_QUOTE, 1'b0);
        add_token_text($urandom_range(0, 2));
        add_byte(BYTE_NUL, 1'b0);
        add_token_text($urandom_range(0, 2));
      end
    end
    if ($urandom_range(0, 9) == 0)
      add_byte(BYTE_BSL, 1'b0);
    r = $urandom_range(0, 99);
    if (r < 85) begin
      add_byte(BYTE_NL, 1'b0);
    end else begin
      add_byte(8'($urandom_range(0, 255)), 1'b1);
      if (r >= 95)
        add_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // hand one byte over, with bursts and gaps on the input side
  task automatic send_row(stim_row_t r);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= r.text;
    s_tlast  <= r.eoi;
    do @(posedge clk); while (!s_tready);
    tokenize_byte(r.text, r.eoi);
    if (r.typed) begin
      made_n = r.count;
      for (int i = 0; i < 3; i++)
        made[i] = r.fixed_res[i];
    end
    for (int i = 0; i < made_n; i++)
      expected_words.push_back('{kind: made[i].kind, ch: made[i].ch,
                                 last: (i == made_n - 1)});
  endtask

  task automatic note_error(string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("%s", msg);
  endtask

  // the receiver changes its stall pattern whenever its run counter reaches zero
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= $urandom_range(0, 3) != 0;
      2:       m_tready <= $urandom_range(0, 3) == 0;
      default: m_tready <= stall_left[1:0] != 2'd0;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        note_error($sformatf("unexpected word kind %0d char %h last %b",
                             m_tuser, m_tdata, m_tlast));
      end else begin
        want = expected_words.pop_front();
        if (m_tuser !== want.kind || m_tdata !== want.ch || m_tlast !== want.last)
          note_error($sformatf(
            "word mismatch: kind %0d/%0d char %h/%h last %b/%b (expected/actual)",
            want.kind, m_tuser, want.ch, m_tdata, want.last, m_tlast));
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (random_text.size() < NUM_RANDOM)
      build_line();
    foreach (DIRECTED_TEXT[i])
      send_row(DIRECTED_TEXT[i]);
    foreach (random_text[i])
      send_row(random_text[i]);
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("quoted_line_tokenizer_top_test: clean");
    end else begin
      $display("quoted_line_tokenizer_top_test: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("quoted_line_tokenizer_top_test: errors");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/qlt_pkg.sv
rtl/quoted_line_tokenizer_top.sv
bench/quoted_line_tokenizer_top_test.sv
